// ----- hw/rtl/red_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response end detector package
// Item codes, status codes, register indexes and the completion marker text.
// ----------------------------------------------------------------------------
package red_pkg;

    localparam int MARK_LEN = 21;
    localparam int DATA_W   = 8;
    localparam int TICK_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Marker text; the first character sits in the top byte.
    localparam logic [DATA_W*MARK_LEN-1:0] MARKER_TEXT = "SER Response Complete";

    localparam logic [DATA_W-1:0] CH_EQ    = 8'h3D;  // '='
    localparam logic [DATA_W-1:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [DATA_W-1:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [DATA_W-1:0] CH_DOLL  = 8'h24;  // '$'
    localparam logic [DATA_W-1:0] CH_QUES  = 8'h3F;  // '?'
    localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
    localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
    localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
    localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;

    localparam logic [TICK_W-1:0] SHORT_IDLE_RST = 16'd80;
    localparam logic [TICK_W-1:0] LONG_IDLE_RST  = 16'd500;
    localparam logic [TICK_W-1:0] OVERALL_RST    = 16'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_IDLE = 2'd0,
        CFG_LONG_IDLE  = 2'd1,
        CFG_OVERALL    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_TICK  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_RUNNING       = 3'd0,
        ST_PROMPT        = 3'd1,
        ST_IDLE_END      = 3'd2,
        ST_TIMEOUT_DATA  = 3'd3,
        ST_TIMEOUT_EMPTY = 3'd4,
        ST_INACTIVE      = 3'd5
    } t_status;

    // Status of the text scanner towards the control logic.
    typedef struct packed {
        logic seen_any;  // at least one byte in this response
        logic hit;       // the presented byte ends the response
    } t_scan_info;

endpackage

// ----- hw/rtl/red_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response end detector text scanner
// Tracks the marker window and the prompt patterns over the received bytes.
// ----------------------------------------------------------------------------
module red_scan import red_pkg::*; #(
    parameter int TAIL_WINDOW = 50
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_step,
    input  logic [DATA_W-1:0] i_data_byte,
    output t_scan_info        o_info
);

    localparam int SPAN_W = $clog2(TAIL_WINDOW + 1);

    logic [DATA_W*MARK_LEN-1:0] r_window, n_window;
    logic [DATA_W-1:0]          r_prev,   n_prev;
    logic [1:0]                 r_count,  n_count;
    logic                       r_armed,  n_armed;
    logic [SPAN_W-1:0]          r_span,   n_span;
    logic                       r_found,  n_found;

    logic c_is_space3;
    logic c_is_space4;
    logic two;

    always_comb begin
        c_is_space3 = (i_data_byte == CH_SPACE) || (i_data_byte == CH_CR)
                   || (i_data_byte == CH_LF);
        c_is_space4 = c_is_space3 || (i_data_byte == CH_TAB);
        two = (r_count != 2'd0)
           && ((((r_prev == CH_GT) || (r_prev == CH_HASH) || (r_prev == CH_DOLL))
                && c_is_space3)
               || ((r_prev == CH_QUES) && (i_data_byte == CH_SPACE)));

        if ((r_count != 2'd0) && (r_prev == CH_EQ) && (i_data_byte == CH_GT)) begin
            n_armed = 1'b1;
            n_span  = SPAN_W'(2);
        end else if (r_armed && c_is_space4 && (r_span < SPAN_W'(TAIL_WINDOW))) begin
            n_armed = 1'b1;
            n_span  = r_span + SPAN_W'(1);
        end else begin
            n_armed = 1'b0;
            n_span  = r_span;
        end

        n_window = {r_window[DATA_W*(MARK_LEN-1)-1:0], i_data_byte};
        n_found  = r_found || (n_window == MARKER_TEXT);
        n_count  = (r_count == 2'd3) ? r_count : r_count + 2'd1;
        n_prev   = i_data_byte;

        o_info.seen_any = (r_count != 2'd0);
        // Three bytes in total are needed once this byte is counted.
        o_info.hit = n_found || ((r_count >= 2'd2) && (n_armed || two));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_window <= '0;
            r_prev   <= '0;
            r_count  <= '0;
            r_armed  <= 1'b0;
            r_span   <= '0;
            r_found  <= 1'b0;
        end else if (i_step) begin
            r_window <= n_window;
            r_prev   <= n_prev;
            r_count  <= n_count;
            r_armed  <= n_armed;
            r_span   <= n_span;
            r_found  <= n_found;
        end
    end

endmodule

// ----- hw/rtl/response_end_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response end detector
// Decides when a command response has ended from bytes, ticks and limits.
// ----------------------------------------------------------------------------
// The result of an item is registered and is valid in the cycle after the item is taken.
// Throughput: one item per cycle; the result register is the only stage.
// Input ready is held low only while an unclaimed result waits and the
// output side is stalled.
// Reset: synchronous, active low; limits return to 80, 500 and 5000 ticks
// and no response is open.
module response_end_detector import red_pkg::*; #(
    parameter int TAIL_WINDOW = 50
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_mode,
    input  logic [DATA_W-1:0]    i_data_byte,
    input  logic                 i_long_idle,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_done_res,
    output logic [2:0]           o_status,
    output logic                 o_have_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]    i_cfg_wdata
);

    logic [TICK_W-1:0] r_short_lim, r_long_lim, r_overall_lim;
    logic              r_active,  n_active;
    logic              r_long,    n_long;
    logic [TICK_W-1:0] r_idle,    n_idle;
    logic [TICK_W-1:0] r_elapsed, n_elapsed;
    logic              r_out_valid;
    logic              r_done,    n_done;
    t_status           r_status,  n_status;
    logic              r_have,    n_have;

    logic              accept;
    logic              scan_clear;
    logic              scan_step;
    t_scan_info        scan_info;
    logic [TICK_W-1:0] idle_inc, elapsed_inc, lim;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    red_scan #(
        .TAIL_WINDOW (TAIL_WINDOW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (scan_clear),
        .i_step      (scan_step),
        .i_data_byte (i_data_byte),
        .o_info      (scan_info)
    );

    always_comb begin
        idle_inc    = (r_idle    == '1) ? r_idle    : r_idle    + TICK_W'(1);
        elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + TICK_W'(1);
        lim         = r_long ? r_long_lim : r_short_lim;

        n_active   = r_active;
        n_long     = r_long;
        n_idle     = r_idle;
        n_elapsed  = r_elapsed;
        n_done     = 1'b0;
        n_status   = r_active ? ST_RUNNING : ST_INACTIVE;
        n_have     = scan_info.seen_any;
        scan_clear = 1'b0;
        scan_step  = 1'b0;

        unique case (t_mode'(i_mode))
            MODE_START: begin
                scan_clear = accept;
                n_active   = 1'b1;
                n_long     = i_long_idle;
                n_idle     = '0;
                n_elapsed  = '0;
                n_status   = ST_RUNNING;
                n_have     = 1'b0;
            end
            MODE_BYTE: begin
                if (r_active) begin
                    scan_step = accept;
                    n_idle    = '0;
                    n_have    = 1'b1;
                    if (scan_info.hit) begin
                        n_done   = 1'b1;
                        n_status = ST_PROMPT;
                    end else if (r_elapsed > r_overall_lim) begin
                        // The total limit may have been lowered under a running count.
                        n_done   = 1'b1;
                        n_status = ST_TIMEOUT_DATA;
                    end
                end
            end
            MODE_TICK: begin
                if (r_active) begin
                    n_idle    = idle_inc;
                    n_elapsed = elapsed_inc;
                    if (scan_info.seen_any && (idle_inc > lim)) begin
                        n_done   = 1'b1;
                        n_status = ST_IDLE_END;
                    end else if (elapsed_inc > r_overall_lim) begin
                        n_done   = 1'b1;
                        n_status = scan_info.seen_any ? ST_TIMEOUT_DATA
                                                      : ST_TIMEOUT_EMPTY;
                    end
                end
            end
            default: begin
                // Unused item code: state is left as it is.
            end
        endcase

        if (n_done) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_lim   <= SHORT_IDLE_RST;
            r_long_lim    <= LONG_IDLE_RST;
            r_overall_lim <= OVERALL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SHORT_IDLE: r_short_lim   <= i_cfg_wdata;
                CFG_LONG_IDLE:  r_long_lim    <= i_cfg_wdata;
                CFG_OVERALL:    r_overall_lim <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_long      <= 1'b0;
            r_idle      <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_active  <= n_active;
                r_long    <= n_long;
                r_idle    <= n_idle;
                r_elapsed <= n_elapsed;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_done   <= n_done;
            r_status <= n_status;
            r_have   <= n_have;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_done_res  = r_done;
    assign o_status    = r_status;
    assign o_have_data = r_have;

endmodule

// ----- sim/response_end_detector_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response end detector checker
// Follows both channels and the limit register port of the detector, keeps a
// model of the open response and compares every result item field by field
// with the verdict predicted when the matching input item was taken.
// ----------------------------------------------------------------------------
module response_end_detector_checker import red_pkg::*; #(
    parameter int TAIL_WINDOW = 50
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [1:0]           i_mode,
    input  logic [DATA_W-1:0]    i_data_byte,
    input  logic                 i_long_idle,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_done_res,
    input  logic [2:0]           i_status,
    input  logic                 i_have_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]    i_cfg_wdata,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_live_items
);

    typedef struct packed {
        logic    done;
        t_status status;
        logic    have_data;
    } t_verdict;

    t_verdict expected_verdicts[$];

    // Limits as last written
    logic [TICK_W-1:0] lim_short;
    logic [TICK_W-1:0] lim_long;
    logic [TICK_W-1:0] lim_total;

    // Model of the open response
    logic                       open_resp;
    logic                       long_sel;
    logic [DATA_W-1:0]          last_byte;
    logic [1:0]                 byte_cnt;
    logic                       prompt_live;
    logic [5:0]                 prompt_len;
    logic [DATA_W*MARK_LEN-1:0] recent_text;
    logic                       marker_seen;
    logic [TICK_W-1:0]          idle_ticks;
    logic [TICK_W-1:0]          total_ticks;

    int fail_total;
    int live_total;

    function automatic void clear_text_state();
        last_byte   = '0;
        byte_cnt    = '0;
        prompt_live = 1'b0;
        prompt_len  = '0;
        recent_text = '0;
        marker_seen = 1'b0;
        idle_ticks  = '0;
        total_ticks = '0;
    endfunction

    // Applies one input item to the model and returns the verdict it causes.
    function automatic t_verdict judge_item(t_mode m, logic [DATA_W-1:0] c, logic lng);
        t_verdict          v;
        logic              two_char;
        logic [TICK_W-1:0] lim;
        v.done   = 1'b0;
        v.status = open_resp ? ST_RUNNING : ST_INACTIVE;
        case (m)
            MODE_START: begin
                clear_text_state();
                open_resp = 1'b1;
                long_sel  = lng;
                v.status  = ST_RUNNING;
            end
            MODE_BYTE: begin
                if (open_resp) begin
                    two_char = (byte_cnt != 2'd0) &&
                        ((((last_byte == CH_GT) || (last_byte == CH_HASH) ||
                           (last_byte == CH_DOLL)) &&
                          ((c == CH_SPACE) || (c == CH_CR) || (c == CH_LF))) ||
                         ((last_byte == CH_QUES) && (c == CH_SPACE)));
                    if ((byte_cnt != 2'd0) && (last_byte == CH_EQ) && (c == CH_GT)) begin
                        prompt_live = 1'b1;
                        prompt_len  = 6'd2;
                    end else if (prompt_live && (prompt_len < TAIL_WINDOW) &&
                                 ((c == CH_SPACE) || (c == CH_CR) ||
                                  (c == CH_LF) || (c == CH_TAB))) begin
                        prompt_len = prompt_len + 6'd1;
                    end else begin
                        prompt_live = 1'b0;
                    end
                    recent_text = {recent_text[DATA_W*(MARK_LEN-1)-1:0], c};
                    if (recent_text == MARKER_TEXT)
                        marker_seen = 1'b1;
                    if (byte_cnt != 2'd3)
                        byte_cnt = byte_cnt + 2'd1;
                    last_byte  = c;
                    idle_ticks = '0;
                    if (marker_seen || ((byte_cnt == 2'd3) && (prompt_live || two_char))) begin
                        v.done   = 1'b1;
                        v.status = ST_PROMPT;
                    end else if (total_ticks > lim_total) begin
                        v.done   = 1'b1;
                        v.status = ST_TIMEOUT_DATA;
                    end
                end
            end
            MODE_TICK: begin
                if (open_resp) begin
                    lim = long_sel ? lim_long : lim_short;
                    if (total_ticks != '1)
                        total_ticks = total_ticks + 1'b1;
                    if (idle_ticks != '1)
                        idle_ticks = idle_ticks + 1'b1;
                    if ((byte_cnt != 2'd0) && (idle_ticks > lim)) begin
                        v.done   = 1'b1;
                        v.status = ST_IDLE_END;
                    end else if (total_ticks > lim_total) begin
                        v.done   = 1'b1;
                        v.status = (byte_cnt != 2'd0) ? ST_TIMEOUT_DATA : ST_TIMEOUT_EMPTY;
                    end
                end
            end
            default: ;
        endcase
        if (v.done)
            open_resp = 1'b0;
        v.have_data = (byte_cnt != 2'd0);
        return v;
    endfunction

    task automatic flag_failure(input string msg);
        fail_total++;
        if (fail_total <= 10)
            $display("[%0t] %s", $realtime, msg);
    endtask

    initial begin
        fail_total = 0;
        live_total = 0;
    end

    always @(posedge i_clk) begin : watch
        t_verdict got;
        t_verdict want;
        if (!i_rst_n) begin
            lim_short = SHORT_IDLE_RST;
            lim_long  = LONG_IDLE_RST;
            lim_total = OVERALL_RST;
            open_resp = 1'b0;
            long_sel  = 1'b0;
            clear_text_state();
            expected_verdicts.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SHORT_IDLE: lim_short = i_cfg_wdata;
                    CFG_LONG_IDLE:  lim_long  = i_cfg_wdata;
                    CFG_OVERALL:    lim_total = i_cfg_wdata;
                    default: ;
                endcase
            end
            // A result leaves before the item taken at the same edge is judged.
            if (i_out_valid && i_out_ready) begin
                got.done      = i_done_res;
                got.status    = t_status'(i_status);
                got.have_data = i_have_data;
                if (expected_verdicts.size() == 0) begin
                    flag_failure($sformatf("unexpected result item: done=%0b status=%0d have_data=%0b",
                        got.done, got.status, got.have_data));
                end else begin
                    want = expected_verdicts.pop_front();
                    if ((got.done !== want.done) || (got.status !== want.status) ||
                        (got.have_data !== want.have_data))
                        flag_failure($sformatf({"result mismatch: expected done=%0b status=%0d ",
                            "have_data=%0b, got done=%0b status=%0d have_data=%0b"},
                            want.done, want.status, want.have_data,
                            got.done, got.status, got.have_data));
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = judge_item(t_mode'(i_mode), i_data_byte, i_long_idle);
                expected_verdicts.push_back(want);
                live_total++;
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_verdicts.size();
        o_live_items <= live_total;
    end

endmodule

// ----- sim/response_end_detector_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response end detector testbench
// Drives start, byte and tick items through the detector under several limit
// settings, with random stalls on both channels, and leaves the checking to
// the checker module placed beside the block.
// ----------------------------------------------------------------------------
module response_end_detector_tb;
    import red_pkg::*;

    localparam int TAIL_WINDOW = 50;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 600000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           in_mode = MODE_START;
    logic [DATA_W-1:0]    in_byte = '0;
    logic                 in_long = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 done_res;
    logic [2:0]           status;
    logic                 have_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SHORT_IDLE;
    logic [TICK_W-1:0]    cfg_wdata = '0;

    int   fail_count;
    int   pending;
    int   live_items;
    int   cycle_count = 0;
    logic send_gaps = 1'b1;
    logic sink_gaps = 1'b1;
    logic hold_req  = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    response_end_detector #(
        .TAIL_WINDOW (TAIL_WINDOW)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_mode      (in_mode),
        .i_data_byte (in_byte),
        .i_long_idle (in_long),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_done_res  (done_res),
        .o_status    (status),
        .o_have_data (have_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    response_end_detector_checker #(
        .TAIL_WINDOW (TAIL_WINDOW)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_mode       (in_mode),
        .i_data_byte  (in_byte),
        .i_long_idle  (in_long),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_done_res   (done_res),
        .i_status     (status),
        .i_have_data  (have_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_live_items (live_items)
    );

    // Result side: random stall bursts, plus one long hold on request.
    initial begin : sink
        int   stall_left;
        int   hold_left;
        logic hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (sink_gaps && ($urandom_range(0, 7) == 0)) begin
                stall_left = $urandom_range(1, 17) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("response_end_detector test failed");
        $finish;
    end

    // Presents one item and returns at the edge where it is taken.
    task automatic offer_item(input t_mode m, input logic [DATA_W-1:0] c, input logic l);
        int gap;
        @(negedge clk);
        if (send_gaps && ($urandom_range(0, 5) == 0)) begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= m;
        in_byte  <= c;
        in_long  <= l;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_start(input logic l);
        offer_item(MODE_START, 8'($urandom_range(0, 255)), l);
    endtask

    task automatic send_byte(input logic [DATA_W-1:0] c);
        offer_item(MODE_BYTE, c, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_tick();
        offer_item(MODE_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic set_limits(input logic [TICK_W-1:0] s, l, o);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SHORT_IDLE;
        cfg_wdata <= s;
        @(negedge clk);
        cfg_index <= CFG_LONG_IDLE;
        cfg_wdata <= l;
        @(negedge clk);
        cfg_index <= CFG_OVERALL;
        cfg_wdata <= o;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Prompt and whitespace characters turn up far more often than chance.
    function automatic logic [DATA_W-1:0] pick_char();
        case ($urandom_range(0, 14))
            0: return CH_EQ;
            1: return CH_GT;
            2: return CH_HASH;
            3: return CH_DOLL;
            4: return CH_QUES;
            5: return CH_SPACE;
            6: return CH_CR;
            7: return CH_LF;
            8: return CH_TAB;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One response: a start, some chatter, then an ending of a random kind.
    // Items that arrive after the response has closed leave its state as it is and report it inactive.
    task automatic random_response();
        int kind;
        int i;
        int bad_pos;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 4))
                offer_item(t_mode'(2'($urandom_range(0, 2))), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
        end else begin
            send_start(1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 12)) begin
                if ($urandom_range(0, 3) == 0)
                    send_tick();
                else
                    send_byte(pick_char());
            end
            case (kind)
                1, 2: begin
                    // A quarter of the markers carry one corrupted character.
                    bad_pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MARK_LEN - 1) : -1;
                    for (i = 0; i < MARK_LEN; i++) begin
                        if (i == bad_pos)
                            send_byte(8'($urandom_range(0, 255)));
                        else
                            send_byte(MARKER_TEXT[DATA_W*(MARK_LEN-1-i) +: DATA_W]);
                    end
                end
                3: begin
                    send_byte(CH_EQ);
                    send_byte(CH_GT);
                    repeat ($urandom_range(0, 3))
                        send_byte(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB);
                    send_byte(pick_char());
                end
                4: begin
                    case ($urandom_range(0, 3))
                        0: send_byte(CH_GT);
                        1: send_byte(CH_HASH);
                        2: send_byte(CH_DOLL);
                        default: send_byte(CH_QUES);
                    endcase
                    case ($urandom_range(0, 3))
                        0: send_byte(CH_SPACE);
                        1: send_byte(CH_CR);
                        2: send_byte(CH_LF);
                        default: send_byte(CH_TAB);
                    endcase
                end
                5, 7: repeat ($urandom_range(1, 40)) send_tick();
                6: begin
                    repeat ($urandom_range(5, 40)) begin
                        send_byte(8'($urandom_range(8'h41, 8'h7A)));
                        repeat ($urandom_range(1, 2)) send_tick();
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic run_random(input int n);
        int target;
        target = live_items + n;
        while (live_items < target)
            random_response();
    endtask

    initial begin : stimulus
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Limits as they come out of reset
        run_random(150);
        wait_for_results();

        // Directed items with the smallest limits
        set_limits(16'd1, 16'd1, 16'd1);
        send_start(1'b0);
        send_tick();
        send_tick();
        send_byte(8'hFF);
        send_tick();
        send_start(1'b0);
        send_byte("a");
        send_tick();
        send_byte("b");
        send_tick();
        send_start(1'b1);
        send_start(1'b0);
        send_byte(CH_GT);
        send_byte(CH_SPACE);
        send_byte(CH_HASH);
        send_byte(CH_CR);
        send_start(1'b1);
        send_byte("a");
        send_byte(CH_EQ);
        send_byte(CH_GT);
        send_start(1'b0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_QUES);
        send_byte(CH_SPACE);
        wait_for_results();

        set_limits(16'd3, 16'd12, 16'd30);
        run_random(200);
        wait_for_results();

        // The result side holds off while items keep coming.
        set_limits(16'hFFFF, 16'd2, 16'd45);
        hold_req = 1'b1;
        run_random(150);
        wait_for_results();

        set_limits(16'd20, 16'hFFFF, 16'd1);
        run_random(150);
        wait_for_results();

        set_limits(16'd6, 16'd9, 16'hFFFF);
        run_random(200);
        wait_for_results();

        send_gaps = 1'b0;
        sink_gaps = 1'b0;
        set_limits(16'd4, 16'd30, 16'd80);
        run_random(200);
        wait_for_results();

        // The largest limits never fire; lowering the total limit under the
        // running count then lets the next byte end the response.
        set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_start(1'b1);
        send_byte("x");
        repeat (40) send_tick();
        send_byte("y");
        wait_for_results();
        set_limits(16'hFFFF, 16'hFFFF, 16'd20);
        send_byte("z");
        wait_for_results();

        repeat (8) @(posedge clk);
        @(negedge clk);
        if ((fail_count == 0) && (pending == 0)) begin
            $display("response_end_detector test passed");
        end else begin
            $display("response_end_detector test failed");
        end
        $finish;
    end

endmodule
